// ===== design/button_debounce_press_events_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Shared property wrappers, clocked on clock, reset is synchronous active high.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_EVENTS_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_EVENTS_MACROS_SVH

// checked only outside reset
`define BDPE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define BDPE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/bdpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpe_pkg
// Types, constants and helpers shared by the button debounce block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdpe_pkg;

   localparam int BUTTONS     = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int LIMITS      = 3;

   localparam int STEP_W     = 10;
   localparam int THR_W      = 16;
   localparam int TIME_W     = 32;
   localparam int CODE_W     = 3;
   localparam int DROP_W     = 2;
   localparam int STB_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_STEP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LIMIT_A       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LIMIT_B       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LIMIT_C       = 3'd4;

   localparam logic [STEP_W-1:0] STEP_RESET      = 10'd10;
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd30;
   localparam logic [TIME_W-1:0] LIMIT_RESET     = 32'd1000;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   localparam logic [CODE_W-1:0] EV_NONE       = 3'd0;
   localparam logic [CODE_W-1:0] EV_SHORT_BASE = 3'd1;
   localparam logic [CODE_W-1:0] EV_LONG_BASE  = 3'd4;

   localparam logic [THR_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic              func;
      logic [2:0]        pressed_bits;
      logic [TIME_W-1:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic [CODE_W-1:0] event_code;
      logic [DROP_W-1:0] dropped;
      logic [STB_W-1:0]  stable_bits;
   } rsp_word_type;

   // what one button lane found on a sample tick
   typedef struct packed {
      logic valid;
      logic is_long;
   } lane_event_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== design/bdpe_lane.sv =====
// ----------------------------------------------------------------------------
// bdpe_lane
// One button: debounce counter, stable level, hold timer and event detect.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdpe_lane (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        tick,
   input  wire logic                        raw,
   input  wire logic [bdpe_pkg::TIME_W-1:0] now_ms,
   input  wire logic [bdpe_pkg::STEP_W-1:0] step,
   input  wire logic [bdpe_pkg::THR_W-1:0]  threshold,
   input  wire logic [bdpe_pkg::TIME_W-1:0] limit,
   output bdpe_pkg::lane_event_type         lane_ev,
   output logic                             stable_nx
);
   import bdpe_pkg::*;

   logic              raw_last_ff, raw_last_in;
   logic              stable_ff, stable_in;
   logic              fired_ff, fired_in;
   logic [THR_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] start_ff, start_in;

   logic              same;
   logic [THR_W:0]    cnt_sum;
   logic [THR_W-1:0]  cnt_sat;
   logic              rise, fall, fired_eff, short_ev, long_ev;
   logic [TIME_W-1:0] start_eff, held;

   always_comb begin
      same    = (raw == raw_last_ff);
      cnt_sum = {1'b0, count_ff} + {{(THR_W - STEP_W + 1){1'b0}}, step};
      cnt_sat = cnt_sum[THR_W] ? COUNT_MAX : cnt_sum[THR_W-1:0];

      stable_nx = (tick && same && (cnt_sat >= threshold)) ? raw : stable_ff;
      rise      = !stable_ff && stable_nx;
      fall      = stable_ff && !stable_nx;

      // a fresh press restarts the hold timer on this very sample
      fired_eff = rise ? 1'b0 : fired_ff;
      start_eff = rise ? now_ms : start_ff;
      held      = now_ms - start_eff;

      short_ev = tick && fall && !fired_ff;
      long_ev  = tick && stable_nx && !fired_eff && (held >= limit);

      lane_ev.valid   = short_ev || long_ev;
      lane_ev.is_long = long_ev;

      raw_last_in = raw_last_ff;
      count_in    = count_ff;
      stable_in   = stable_ff;
      start_in    = start_ff;
      fired_in    = fired_ff;
      if (tick) begin
         if (same) begin
            count_in = cnt_sat;
         end else begin
            raw_last_in = raw;
            count_in    = '0;
         end
         stable_in = stable_nx;
         start_in  = start_eff;
         // long flag sticks even if the ring drops the word
         fired_in  = fall ? 1'b0 : (long_ev ? 1'b1 : fired_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_last_ff <= 1'b0;
         stable_ff   <= 1'b0;
         fired_ff    <= 1'b0;
         count_ff    <= '0;
         start_ff    <= '0;
      end else begin
         raw_last_ff <= raw_last_in;
         stable_ff   <= stable_in;
         fired_ff    <= fired_in;
         count_ff    <= count_in;
         start_ff    <= start_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bdpe_ring.sv =====
// ----------------------------------------------------------------------------
// bdpe_ring
// Merges lane events in button order into the event ring; pops on read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdpe_ring (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          tick,
   input  wire logic                          read,
   input  bdpe_pkg::lane_event_type           lane_ev [bdpe_pkg::BUTTONS],
   output logic [bdpe_pkg::CODE_W-1:0]        event_code,
   output logic [bdpe_pkg::DROP_W-1:0]        dropped
);
   import bdpe_pkg::*;
   `include "button_debounce_press_events_macros.svh"

   logic [CODE_W-1:0] ring_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;

   logic              wr_en   [BUTTONS];
   logic [PTR_W-1:0]  wr_addr [BUTTONS];
   logic [CODE_W-1:0] wr_code [BUTTONS];

   // pushes chain through the tail; a push that would reach head is dropped
   always_comb begin
      logic [PTR_W-1:0] t;
      logic [PTR_W-1:0] nt;
      t       = tail_ff;
      dropped = '0;
      for (int k = 0; k < BUTTONS; k++) begin
         nt         = ptr_next(t);
         wr_en[k]   = 1'b0;
         wr_addr[k] = t;
         wr_code[k] = lane_ev[k].is_long ? (EV_LONG_BASE + CODE_W'(k))
                                         : (EV_SHORT_BASE + CODE_W'(k));
         if (tick && lane_ev[k].valid) begin
            if (nt == head_ff) begin
               if (dropped != '1) begin
                  dropped = dropped + DROP_W'(1);
               end
            end else begin
               wr_en[k] = 1'b1;
               t        = nt;
            end
         end
      end
      tail_in = t;
   end

   always_comb begin
      event_code = EV_NONE;
      head_in    = head_ff;
      if (read && (head_ff != tail_ff)) begin
         event_code = ring_ff[head_ff];
         head_in    = ptr_next(head_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < BUTTONS; k++) begin
         if (wr_en[k]) begin
            ring_ff[wr_addr[k]] <= wr_code[k];
         end
      end
   end

   `BDPE_ASSERT(a_ptr_range, (head_ff < QUEUE_DEPTH) && (tail_ff < QUEUE_DEPTH), "ring pointer out of range")
   `BDPE_ASSERT(a_drop_on_tick, (dropped != '0) |-> tick, "drop reported outside a sample tick")
   `BDPE_ASSERT(a_read_keeps_tail, read |=> (tail_ff == $past(tail_ff)), "read moved the tail")
   `BDPE_ASSERT(a_pop_moves_head, (read && (head_ff != tail_ff)) |=> (head_ff != $past(head_ff)), "pop did not advance head")

endmodule

`default_nettype wire

// ===== design/button_debounce_press_events.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_events
// Debounce for three push buttons with short and long press events.
//
// Input channel req_: one word per item. func sample carries the raw pressed
// bits and the ms time; every button lane updates its debounce counter and
// hold timer, and new events go into an 8 slot ring (7 usable, extra events
// are dropped and counted). func read pops the oldest event, or none.
// Result channel rsp_: exactly one word per item, with the popped event,
// the drop count of the tick and the debounced levels after the item.
// csr_: write-only register port, applied at the edge where csr_we is high;
// write only while the block is idle.
// Output: the result is registered; under a stall it waits in the skid register.
// Throughput: one item per cycle unless stalled; every lane and the ring
// merge finish in the accepting cycle; the state is at once ready again.
// Stall: an output register plus one skid register; req_ready drops only
// when both hold words the receiver has not taken.
// Reset: all buttons released, counters and timers clear, ring empty,
// registers at their defaults (step 10, threshold 30, limits 1000 ms).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_press_events (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  bdpe_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output bdpe_pkg::rsp_word_type               rsp_word,
   input  wire logic                            csr_we,
   input  wire logic [bdpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bdpe_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bdpe_pkg::*;
   `include "button_debounce_press_events_macros.svh"

   logic [STEP_W-1:0] step_ff, step_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [TIME_W-1:0] limit_ff [LIMITS];
   logic [TIME_W-1:0] limit_in [LIMITS];

   logic           accept, tick, read, pop;
   lane_event_type lane_ev [BUTTONS];
   logic [BUTTONS-1:0] stable_vec;
   logic [CODE_W-1:0]  rd_code;
   logic [DROP_W-1:0]  drops;
   rsp_word_type       result;

   logic         out_v_ff, out_v_in;
   logic         skid_v_ff, skid_v_in;
   rsp_word_type out_ff, out_in;
   rsp_word_type skid_ff, skid_in;

   assign req_ready = !skid_v_ff;
   assign accept    = req_valid && req_ready;
   assign tick      = accept && (req_word.func == FUNC_SAMPLE);
   assign read      = accept && (req_word.func == FUNC_READ);
   assign pop       = out_v_ff && rsp_ready;

   always_comb begin
      step_in = step_ff;
      thr_in  = thr_ff;
      for (int i = 0; i < LIMITS; i++) begin
         limit_in[i] = limit_ff[i];
      end
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_STEP:      step_in     = csr_wdata[STEP_W-1:0];
            CSR_DEBOUNCE_THRESHOLD: thr_in      = csr_wdata[THR_W-1:0];
            CSR_LONG_LIMIT_A:       limit_in[0] = csr_wdata[TIME_W-1:0];
            CSR_LONG_LIMIT_B:       limit_in[1] = csr_wdata[TIME_W-1:0];
            CSR_LONG_LIMIT_C:       limit_in[2] = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         thr_ff  <= THRESHOLD_RESET;
         for (int i = 0; i < LIMITS; i++) begin
            limit_ff[i] <= LIMIT_RESET;
         end
      end else begin
         step_ff <= step_in;
         thr_ff  <= thr_in;
         for (int i = 0; i < LIMITS; i++) begin
            limit_ff[i] <= limit_in[i];
         end
      end
   end

   for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
      bdpe_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .tick      (tick),
         .raw       (req_word.pressed_bits[g]),
         .now_ms    (req_word.now_ms),
         .step      (step_ff),
         .threshold (thr_ff),
         .limit     (limit_ff[g]),
         .lane_ev   (lane_ev[g]),
         .stable_nx (stable_vec[g])
      );
   end

   bdpe_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .read       (read),
      .lane_ev    (lane_ev),
      .event_code (rd_code),
      .dropped    (drops)
   );

   always_comb begin
      result.event_code  = rd_code;
      result.dropped     = drops;
      result.stable_bits = STB_W'(stable_vec);
   end

   // output word plus one skid word
   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (pop) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_v_ff || pop) begin
            out_in   = result;
            out_v_in = 1'b1;
         end else begin
            skid_in   = result;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_word  = out_ff;

   `BDPE_ASSERT_ALWAYS(a_skid_needs_out, skid_v_ff |-> out_v_ff, "skid word without output word")
   `BDPE_ASSERT(a_accept_fills_out, accept |=> out_v_ff, "accepted item left no result word")
   `BDPE_ASSERT(a_skid_only_on_stall, (!$past(skid_v_ff) && skid_v_ff) |-> $past(out_v_ff && !rsp_ready), "skid filled without a stall")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for button_debounce_press_events. A behavioral copy of
// the debounce lanes and the event ring predicts one rsp word per req word;
// a monitor compares every rsp word field by field, in order. Directed tests
// hit the press/release/long cases, time wrap, zero settings and ring
// overflow. Random phases follow with new register settings each time,
// bursty req traffic and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import bdpe_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_word;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   button_debounce_press_events DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [STEP_W-1:0] m_step;
   logic [THR_W-1:0]  m_thr;
   logic [TIME_W-1:0] m_limit [BUTTONS];
   logic              m_raw [BUTTONS];
   logic              m_level [BUTTONS];
   logic              m_level_prev [BUTTONS];
   logic              m_long_done [BUTTONS];
   logic [THR_W-1:0]  m_count [BUTTONS];
   logic [TIME_W-1:0] m_press_t [BUTTONS];
   logic [CODE_W-1:0] m_ring [QUEUE_DEPTH];
   int                m_head;
   int                m_tail;

   rsp_word_type      due_rsp [$];
   rsp_word_type      due_word;
   int                err_count;
   int                burst_left;
   logic [2:0]        held_bits;
   logic [TIME_W-1:0] now_t;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int ring_adv(int p);
      return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
   endfunction

   // returns 1 when the ring is full and the event is lost
   function automatic int queue_event(logic [CODE_W-1:0] code);
      if (ring_adv(m_tail) == m_head) begin
         return 1;
      end
      m_ring[m_tail] = code;
      m_tail = ring_adv(m_tail);
      return 0;
   endfunction

   function automatic rsp_word_type debounce_predict(req_word_type w);
      rsp_word_type      r;
      int                drops;
      int unsigned       sum;
      logic [TIME_W-1:0] held;
      r     = '0;
      drops = 0;
      if (w.func == FUNC_SAMPLE) begin
         // debounce every lane before any event logic
         for (int i = 0; i < BUTTONS; i++) begin
            if (w.pressed_bits[i] == m_raw[i]) begin
               sum = m_count[i] + m_step;
               m_count[i] = (sum > COUNT_MAX) ? COUNT_MAX : THR_W'(sum);
               if (m_count[i] >= m_thr) begin
                  m_level[i] = w.pressed_bits[i];
               end
            end else begin
               m_raw[i]   = w.pressed_bits[i];
               m_count[i] = '0;
            end
         end
         for (int i = 0; i < BUTTONS; i++) begin
            if (!m_level_prev[i] && m_level[i]) begin
               m_press_t[i]   = w.now_ms;
               m_long_done[i] = 1'b0;
            end
            if (m_level_prev[i] && !m_level[i]) begin
               if (!m_long_done[i]) begin
                  drops += queue_event(EV_SHORT_BASE + CODE_W'(i));
               end
               m_long_done[i] = 1'b0;
            end
            if (m_level[i] && !m_long_done[i]) begin
               held = w.now_ms - m_press_t[i];
               if (held >= m_limit[i]) begin
                  drops += queue_event(EV_LONG_BASE + CODE_W'(i));
                  m_long_done[i] = 1'b1;
               end
            end
            m_level_prev[i] = m_level[i];
         end
         r.dropped = (drops > 3) ? '1 : DROP_W'(drops);
      end else if (m_head != m_tail) begin
         r.event_code = m_ring[m_head];
         m_head = ring_adv(m_head);
      end
      for (int i = 0; i < BUTTONS; i++) begin
         r.stable_bits[i] = m_level[i];
      end
      return r;
   endfunction

   task automatic clear_model();
      m_step = STEP_RESET;
      m_thr  = THRESHOLD_RESET;
      for (int i = 0; i < BUTTONS; i++) begin
         m_limit[i]      = LIMIT_RESET;
         m_raw[i]        = 1'b0;
         m_level[i]      = 1'b0;
         m_level_prev[i] = 1'b0;
         m_long_done[i]  = 1'b0;
         m_count[i]      = '0;
         m_press_t[i]    = '0;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         m_ring[i] = EV_NONE;
      end
      m_head = 0;
      m_tail = 0;
   endtask

   // ---------------------------------------------------------------- checker

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp.size() == 0) begin
            $display("%0t: rsp word with none expected, expected none, actual %p",
                     $time, rsp_word);
            err_count++;
         end else begin
            due_word = due_rsp.pop_front();
            check_field("event_code", 8'(due_word.event_code), 8'(rsp_word.event_code));
            check_field("dropped", 8'(due_word.dropped), 8'(rsp_word.dropped));
            check_field("stable_bits", 8'(due_word.stable_bits),
                        8'(rsp_word.stable_bits));
         end
      end
   end

   // receiver: calm stretches and choppy stretches with short stall runs
   initial begin
      int   stall_run;
      int   mode_left;
      logic choppy;
      rsp_ready = 1'b1;
      stall_run = 0;
      mode_left = 0;
      choppy    = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode_left = $urandom_range(30, 300);
            choppy    = ($urandom_range(0, 3) != 0);
         end
         mode_left--;
         if (stall_run > 0) begin
            rsp_ready <= 1'b0;
            stall_run--;
         end else begin
            rsp_ready <= 1'b1;
            if (choppy && $urandom_range(0, 2) == 0) begin
               stall_run = $urandom_range(1, 7);
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_word(req_word_type w);
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      due_rsp.push_back(debounce_predict(w));
   endtask

   task automatic send_item(req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      send_word(w);
   endtask

   function automatic req_word_type sample_word(logic [2:0] bits, logic [TIME_W-1:0] t);
      req_word_type w;
      w.func         = FUNC_SAMPLE;
      w.pressed_bits = bits;
      w.now_ms       = t;
      return w;
   endfunction

   // unused fields of a read carry junk
   function automatic req_word_type read_word();
      req_word_type w;
      w.func         = FUNC_READ;
      w.pressed_bits = 3'($urandom);
      w.now_ms       = $urandom;
      return w;
   endfunction

   task automatic hold_level(logic [2:0] bits, int n, logic [TIME_W-1:0] t0, int dt);
      for (int k = 0; k < n; k++) begin
         send_item(sample_word(bits, t0 + TIME_W'(k * dt)));
      end
   endtask

   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_STEP:      m_step     = data[STEP_W-1:0];
         CSR_DEBOUNCE_THRESHOLD: m_thr      = data[THR_W-1:0];
         CSR_LONG_LIMIT_A:       m_limit[0] = data;
         CSR_LONG_LIMIT_B:       m_limit[1] = data;
         CSR_LONG_LIMIT_C:       m_limit[2] = data;
         default: ;
      endcase
   endtask

   function automatic logic [TIME_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return LIMIT_RESET;
         3:       return $urandom;
         default: return $urandom_range(20, 800);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_default_presses();
      send_item(read_word());                              // empty ring
      hold_level(3'b001, 4, 32'd0, 10);
      hold_level(3'b000, 4, 32'd40, 10);                   // short press, button 1
      send_item(read_word());
      // all three held across the 32-bit time wrap, then long events
      hold_level(3'b111, 4, 32'hFFFF_FF00, 16);
      send_item(sample_word(3'b111, 32'hFFFF_FFFF));
      send_item(sample_word(3'b111, 32'h0000_0400));
      repeat (3) send_item(read_word());
   endtask

   task automatic test_zero_settings_overflow();
      wait_idle();
      csr_write(CSR_DEBOUNCE_STEP, '0);
      csr_write(CSR_DEBOUNCE_THRESHOLD, '0);
      csr_write(CSR_LONG_LIMIT_A, '0);
      csr_write(CSR_LONG_LIMIT_B, '0);
      csr_write(CSR_LONG_LIMIT_C, '0);
      // indexes past the register list must be ignored
      for (int idx = int'(CSR_LONG_LIMIT_C) + 1; idx < (1 << CSR_IDX_W); idx++) begin
         csr_write(CSR_IDX_W'(idx), $urandom);
      end
      // each press fires three longs at once; the ring fills, then drops
      for (int k = 0; k < 4; k++) begin
         hold_level(3'b000, 2, 32'h1234_0000 + 32'(k * 100), 5);
         hold_level(3'b111, 2, 32'h1234_0050 + 32'(k * 100), 5);
      end
      repeat (2) send_item(read_word());
   endtask

   task automatic random_items(int n, int churn, int noise);
      req_word_type w;
      logic [2:0]   bits;
      int           r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            w.func         = 1'($urandom);
            w.pressed_bits = 3'($urandom);
            w.now_ms       = $urandom;
         end else if (r < 28) begin
            w = read_word();
         end else begin
            for (int i = 0; i < BUTTONS; i++) begin
               if ($urandom_range(0, churn) == 0) held_bits[i] = ~held_bits[i];
            end
            bits = held_bits;
            for (int i = 0; i < BUTTONS; i++) begin
               if ($urandom_range(0, 99) < noise) bits[i] = ~bits[i];   // bounce
            end
            case ($urandom_range(0, 19))
               0:       now_t = $urandom;
               1, 2:    now_t += $urandom_range(0, 4000);
               default: now_t += $urandom_range(0, 120);
            endcase
            w = sample_word(bits, now_t);
         end
         send_item(w);
      end
   endtask

   task automatic test_random_phases();
      int unsigned st;
      int unsigned th;
      int          churn;
      int          noise;
      int          n;
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         if (p == 0) begin
            // max step and threshold: counter saturation on long holds
            st = 1023; th = 65535; churn = 150; noise = 0; n = 150;
         end else begin
            case ($urandom_range(0, 4))
               0:       st = 0;
               1:       st = 1;
               2:       st = 10;
               3:       st = $urandom_range(1, 1000);
               default: st = 1023;
            endcase
            case ($urandom_range(0, 3))
               0:       th = 0;
               3:       th = $urandom_range(0, 65535);
               default: th = st * $urandom_range(1, 5);
            endcase
            if (th > 65535) th = 65535;
            churn = $urandom_range(4, 30);
            noise = $urandom_range(0, 12);
            n     = 90;
         end
         csr_write(CSR_DEBOUNCE_STEP, ($urandom & ~32'h3FF) | st);
         csr_write(CSR_DEBOUNCE_THRESHOLD, ($urandom & ~32'hFFFF) | th);
         for (int i = 0; i < BUTTONS; i++) begin
            csr_write(CSR_LONG_LIMIT_A + CSR_IDX_W'(i), pick_limit());
         end
         random_items(n, churn, noise);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_word   = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      err_count  = 0;
      burst_left = 0;
      held_bits  = '0;
      now_t      = '0;
      clear_model();
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_default_presses();
      test_zero_settings_overflow();
      test_random_phases();
      wait_idle();

      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/bdpe_pkg.sv
design/bdpe_lane.sv
design/bdpe_ring.sv
design/button_debounce_press_events.sv
test/tb.sv
